[rtl/core/bfpu_pkg.sv]
// shared types and constants for the bit field packer and unpacker
package bfpu_pkg;

   localparam int STORE_BYTES    = 1024;
   localparam int MAX_FIELD_BITS = 32;
   localparam int ADDR_W         = $clog2(STORE_BYTES);
   localparam int CURSOR_W       = ADDR_W + 3;
   localparam int SIZE_W         = ADDR_W + 1;
   localparam int WIDTH_W        = 6;
   localparam int VALUE_W        = 32;

   typedef enum logic [2:0] {
      CMD_WRITE_FIELD = 3'd0,
      CMD_READ_FIELD  = 3'd1,
      CMD_REWIND      = 3'd2,
      CMD_RESET       = 3'd3,
      CMD_LOAD_BYTE   = 3'd4,
      CMD_FETCH_BYTE  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_WIDTH = 2'd1,
      STAT_NO_ROOM   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MEM_WALK = 2'd0,
      MEM_NEXT = 2'd1,
      MEM_REQ  = 2'd2
   } mem_src_type;

   typedef struct packed {
      cmd_type              command;
      logic [WIDTH_W-1:0]   field_width;
      logic                 sign_extend;
      logic [VALUE_W-1:0]   field_value;
      logic [9:0]           byte_address;
      logic [7:0]           byte_data;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   read_value;
      status_type           status;
      logic [10:0]          bytes_written;
      logic [10:0]          bytes_consumed;
      logic [12:0]          cursor_bit;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      logic        execute;
      logic        mem_rd;
      logic        mem_wr;
      mem_src_type mem_src;
      logic        walk_step;
      logic        walk_acc;
      logic        take_fetch;
      logic        load_rsp;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type    command;
      status_type check;
      logic       mid_byte;
      logic       step_last;
   } dp_stat_type;

endpackage

[rtl/core/bfpu_ctrl.sv]
// sequencer for field, byte and cursor commands
module bfpu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bfpu_pkg::dp_stat_type stat,
   output bfpu_pkg::ctrl_cmd_type cmd
);
   import bfpu_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WR_READ,
      S_WR_STEP,
      S_RD_READ,
      S_RD_STEP,
      S_FETCH,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mem_src = MEM_WALK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            unique case (stat.command)
               CMD_WRITE_FIELD: begin
                  if (stat.check != STAT_OK)
                     state_in = S_FINISH;
                  else if (stat.mid_byte)
                     state_in = S_WR_READ;
                  else
                     state_in = S_WR_STEP;
               end
               CMD_READ_FIELD: begin
                  state_in = (stat.check != STAT_OK) ? S_FINISH : S_RD_READ;
               end
               CMD_LOAD_BYTE: begin
                  cmd.mem_wr  = 1'b1;
                  cmd.mem_src = MEM_REQ;
                  state_in    = S_FINISH;
               end
               CMD_FETCH_BYTE: begin
                  cmd.mem_rd  = 1'b1;
                  cmd.mem_src = MEM_REQ;
                  state_in    = S_FETCH;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_WR_READ: begin
            // partly used byte needs its old bits
            cmd.mem_rd = 1'b1;
            state_in   = S_WR_STEP;
         end
         S_WR_STEP: begin
            cmd.mem_wr    = 1'b1;
            cmd.walk_step = 1'b1;
            if (stat.step_last)
               state_in = S_FINISH;
         end
         S_RD_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_RD_STEP;
         end
         S_RD_STEP: begin
            cmd.walk_step = 1'b1;
            cmd.walk_acc  = 1'b1;
            if (stat.step_last) begin
               state_in = S_FINISH;
            end else begin
               // fetch the following byte while this one is merged
               cmd.mem_rd  = 1'b1;
               cmd.mem_src = MEM_NEXT;
            end
         end
         S_FETCH: begin
            cmd.take_fetch = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (state_ff == S_IDLE))
      else $error("word accepted outside idle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_one_mem_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_rd && cmd.mem_wr))
      else $error("store read and write in one cycle");

endmodule

[rtl/core/bfpu_dpath.sv]
// byte store, bit cursor, field walk and result register
module bfpu_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  bfpu_pkg::req_type      req_word,
   output bfpu_pkg::rsp_type      rsp_word,
   input  logic                   csr_wr_en,
   input  logic [10:0]            csr_wr_data,
   input  bfpu_pkg::ctrl_cmd_type cmd,
   output bfpu_pkg::dp_stat_type  stat
);
   import bfpu_pkg::*;

   function automatic logic [VALUE_W-1:0] low_mask32(input logic [WIDTH_W-1:0] n);
      logic [VALUE_W:0] full;
      full = ({{VALUE_W{1'b0}}, 1'b1} << n) - {{VALUE_W{1'b0}}, 1'b1};
      if (n >= WIDTH_W'(VALUE_W))
         return '1;
      return full[VALUE_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] touched(input logic [CURSOR_W-1:0] c);
      return SIZE_W'(c[CURSOR_W-1:3]) + SIZE_W'(|c[2:0]);
   endfunction

   logic [7:0]          byte_store_ff [STORE_BYTES];
   logic [7:0]          mem_q_ff;
   logic [ADDR_W-1:0]   mem_addr;
   logic [7:0]          mem_wdata;

   req_type             req_ff;
   logic [SIZE_W-1:0]   lim_ff, lim_eff;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [SIZE_W-1:0]   written_ff, written_in;
   logic [SIZE_W-1:0]   consumed_ff, consumed_in;

   logic [VALUE_W-1:0]  walk_val_ff, walk_val_in;
   logic [WIDTH_W-1:0]  walk_off_ff, walk_off_in;
   logic [WIDTH_W-1:0]  walk_rem_ff, walk_rem_in;
   logic [ADDR_W-1:0]   walk_addr_ff, walk_addr_in;
   logic [2:0]          walk_p_ff, walk_p_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   status_type          res_status_ff, res_status_in;
   rsp_type             rsp_ff;

   logic [CURSOR_W:0]   end_bit;
   status_type          check;
   logic [3:0]          room, take;
   logic [2:0]          sd;
   logic [7:0]          tmask, keep, wbyte, rbits;
   logic [VALUE_W-1:0]  vsh, acc_next, ext;
   logic [4:0]          top_idx;
   logic                last;

   // width check first, then the end byte against the usable size
   assign lim_eff = (lim_ff > SIZE_W'(STORE_BYTES)) ? SIZE_W'(STORE_BYTES) : lim_ff;
   assign end_bit = {1'b0, cursor_ff} + (CURSOR_W + 1)'(req_ff.field_width);

   always_comb begin
      if (req_ff.field_width == '0 || req_ff.field_width > WIDTH_W'(MAX_FIELD_BITS))
         check = STAT_BAD_WIDTH;
      else if (SIZE_W'(end_bit[CURSOR_W:3]) >= lim_eff)
         check = STAT_NO_ROOM;
      else
         check = STAT_OK;
   end

   // one store byte of the field per step
   assign room  = 4'd8 - {1'b0, walk_p_ff};
   assign last  = (walk_rem_ff <= {2'b00, room});
   assign take  = last ? walk_rem_ff[3:0] : room;
   assign sd    = 3'(room - take);
   assign tmask = 8'((9'd1 << take) - 9'd1);
   assign vsh   = walk_val_ff >> walk_off_ff;
   assign keep  = (walk_p_ff != 3'd0) ? mem_q_ff : 8'd0;
   assign wbyte = keep | 8'((vsh[7:0] & tmask) << sd);
   assign rbits = (mem_q_ff >> sd) & tmask;
   assign acc_next = acc_ff | ({{(VALUE_W-8){1'b0}}, rbits} << walk_off_ff);

   assign top_idx = 5'(req_ff.field_width - WIDTH_W'(1));
   always_comb begin
      ext = acc_next;
      if (req_ff.sign_extend && req_ff.field_width < WIDTH_W'(VALUE_W) && acc_next[top_idx])
         ext = acc_next | ~low_mask32(req_ff.field_width);
   end

   always_comb begin
      cursor_in     = cursor_ff;
      written_in    = written_ff;
      consumed_in   = consumed_ff;
      walk_val_in   = walk_val_ff;
      walk_off_in   = walk_off_ff;
      walk_rem_in   = walk_rem_ff;
      walk_addr_in  = walk_addr_ff;
      walk_p_in     = walk_p_ff;
      acc_in        = acc_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      if (cmd.execute) begin
         res_value_in  = '0;
         res_status_in = STAT_OK;
         acc_in        = '0;
         walk_val_in   = req_ff.field_value & low_mask32(req_ff.field_width);
         walk_off_in   = '0;
         walk_rem_in   = req_ff.field_width;
         walk_addr_in  = cursor_ff[CURSOR_W-1:3];
         walk_p_in     = cursor_ff[2:0];
         unique case (req_ff.command) inside
            CMD_WRITE_FIELD, CMD_READ_FIELD: begin
               res_status_in = check;
               if (check == STAT_OK) begin
                  cursor_in = end_bit[CURSOR_W-1:0];
                  if (req_ff.command == CMD_WRITE_FIELD)
                     written_in = touched(end_bit[CURSOR_W-1:0]);
                  else
                     consumed_in = touched(end_bit[CURSOR_W-1:0]);
               end
            end
            CMD_REWIND: begin
               cursor_in   = '0;
               consumed_in = '0;
            end
            CMD_RESET: begin
               cursor_in   = '0;
               written_in  = '0;
               consumed_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (cmd.walk_step) begin
         walk_off_in  = walk_off_ff + WIDTH_W'(take);
         walk_rem_in  = walk_rem_ff - WIDTH_W'(take);
         walk_addr_in = walk_addr_ff + ADDR_W'(1);
         walk_p_in    = 3'd0;
      end
      if (cmd.walk_acc) begin
         acc_in = acc_next;
         if (last)
            res_value_in = ext;
      end
      if (cmd.take_fetch)
         res_value_in = {{(VALUE_W-8){1'b0}}, mem_q_ff};
   end

   always_comb begin
      unique case (cmd.mem_src)
         MEM_WALK: mem_addr = walk_addr_ff;
         MEM_NEXT: mem_addr = walk_addr_ff + ADDR_W'(1);
         MEM_REQ:  mem_addr = req_ff.byte_address;
         default:  mem_addr = walk_addr_ff;
      endcase
      mem_wdata = (cmd.mem_src == MEM_REQ) ? req_ff.byte_data : wbyte;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr)
         byte_store_ff[mem_addr] <= mem_wdata;
      if (cmd.mem_rd)
         mem_q_ff <= byte_store_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture)
         req_ff <= req_word;
      walk_val_ff   <= walk_val_in;
      walk_off_ff   <= walk_off_in;
      walk_rem_ff   <= walk_rem_in;
      walk_addr_ff  <= walk_addr_in;
      walk_p_ff     <= walk_p_in;
      acc_ff        <= acc_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (cmd.load_rsp) begin
         rsp_ff.read_value     <= res_value_ff;
         rsp_ff.status         <= res_status_ff;
         rsp_ff.bytes_written  <= written_ff;
         rsp_ff.bytes_consumed <= consumed_ff;
         rsp_ff.cursor_bit     <= cursor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff      <= SIZE_W'(STORE_BYTES);
         cursor_ff   <= '0;
         written_ff  <= '0;
         consumed_ff <= '0;
      end else begin
         if (csr_wr_en)
            lim_ff <= csr_wr_data;
         cursor_ff   <= cursor_in;
         written_ff  <= written_in;
         consumed_ff <= consumed_in;
      end
   end

   assign rsp_word       = rsp_ff;
   assign stat.command   = req_ff.command;
   assign stat.check     = check;
   assign stat.mid_byte  = (cursor_ff[2:0] != 3'd0);
   assign stat.step_last = last;

   a_sizes_bound: assert property (@(posedge clock) disable iff (reset)
      (written_ff <= SIZE_W'(STORE_BYTES)) && (consumed_ff <= SIZE_W'(STORE_BYTES)))
      else $error("byte count beyond store");

   a_step_has_bits: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (walk_rem_ff != '0))
      else $error("walk step with no bits left");

   a_step_aligns: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_step && !last) |=> (walk_p_ff == 3'd0 && walk_rem_ff != '0))
      else $error("walk left mid byte with bits pending");

endmodule

[rtl/core/bit_field_packer_unpacker.sv]
// top level of the bit field packer and unpacker
//
//   channel   ports                         direction   moves
//   request   req_valid/req_ready/req_word  in          one command word
//   response  rsp_valid/rsp_ready/rsp_word  out         one result word per command
//   config    csr_wr_en/csr_wr_data         in          usable store size in bytes
//
// writes and reads walk the 1 to 5 store bytes a field touches, one per cycle through
// the single-port byte store; a write that starts inside a byte first reads its old bits.
// refused fields, cursor, reset and load commands finish from execute, fetch via S_FETCH.
// synchronous reset clears cursor and sizes and sets the size limit to the full store.
// a stalled response holds the next command in its last cycle; no request is taken
// until that command hands over its word.
module bit_field_packer_unpacker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfpu_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfpu_pkg::rsp_type rsp_word,
   input  logic              csr_wr_en,
   input  logic [10:0]       csr_wr_data
);
   import bfpu_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   bfpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfpu_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
